// ===== rtl/fepa_pkg.sv =====
package fepa_pkg;

    localparam int PAGE_BITS  = 34;
    localparam int COUNT_BITS = PAGE_BITS + 1;
    localparam int SLOTS      = 1024;
    localparam int ADDR_BITS  = $clog2(SLOTS);
    localparam int NUM_BITS   = ADDR_BITS + 1;
    localparam int IN_BITS    = PAGE_BITS + 2 * COUNT_BITS;
    localparam int IN_BYTES   = (IN_BITS + 7) / 8;
    localparam int OUT_BITS   = 3 + PAGE_BITS + COUNT_BITS;
    localparam int OUT_BYTES  = (OUT_BITS + 7) / 8;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOFIT   = 3'd1;
    localparam logic [2:0] ST_BADREL  = 3'd2;
    localparam logic [2:0] ST_OVERLAP = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic [COUNT_BITS-1:0] LIMIT_RESET = COUNT_BITS'(1) << PAGE_BITS;

    typedef struct packed {
        logic [COUNT_BITS-1:0] hi;
        logic [COUNT_BITS-1:0] lo;
    } ext_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] total;
        logic [PAGE_BITS-1:0]  granted;
        logic [2:0]            status;
    } res_t;

endpackage

// ===== rtl/free_extent_page_allocator.sv =====
// Free page extent allocator, first fit with coalescing of released ranges.
// Requests arrive as beats on the s_ side: s_tuser selects allocate (0) or
// release (1), s_tdata carries page number, page count and limit page.
// Each request yields exactly one beat on the m_ side with status, the
// granted page and the free page total after the request.
// cfg_we writes the exclusive page limit; write it only while idle.
// The extent table sits in one RAM with a registered read. Each scan step
// of a request is a RAM read followed by a compare state, and each shift
// step is a RAM read followed by a write.
// Reset empties the table, clears the free total and sets the limit to
// 2^34 pages; no clearing pass is needed.
// A finished result sits in the output register; the next request is taken
// while it waits. A further result waits inside the core until the output
// register is free, and no new beat is accepted meanwhile.
module free_extent_page_allocator
    import fepa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // page_number, page_count, limit_page
    input  logic [IN_BYTES*8-1:0]   s_tdata,
    // action
    input  logic [0:0]              s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // status, granted_page, free_total
    output logic [OUT_BYTES*8-1:0]  m_tdata,
    input  logic                    cfg_we,
    input  logic [COUNT_BITS-1:0]   cfg_wdata
);

    logic  res_valid;
    logic  res_ready;
    res_t  res;
    logic  m_valid_reg;
    res_t  m_data_reg;

    fepa_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req_action (s_tuser[0]),
        .req_page   (s_tdata[PAGE_BITS-1:0]),
        .req_count  (s_tdata[PAGE_BITS+COUNT_BITS-1:PAGE_BITS]),
        .req_limit  (s_tdata[IN_BITS-1:PAGE_BITS+COUNT_BITS]),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = (OUT_BYTES*8)'(m_data_reg);

endmodule

// ===== rtl/fepa_ram.sv =====
module fepa_ram
    import fepa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output ext_t                 rd_data,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  ext_t                 wr_data
);

    ext_t mem [SLOTS];
    ext_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/fepa_core.sv =====
module fepa_core
    import fepa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [COUNT_BITS-1:0] cfg_wdata,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  logic                  req_action,
    input  logic [PAGE_BITS-1:0]  req_page,
    input  logic [COUNT_BITS-1:0] req_count,
    input  logic [COUNT_BITS-1:0] req_limit,
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_t                  res
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_AL_RD  = 4'd1;
    localparam logic [3:0] S_AL_CHK = 4'd2;
    localparam logic [3:0] S_DN_RD  = 4'd3;
    localparam logic [3:0] S_DN_WR  = 4'd4;
    localparam logic [3:0] S_RL_RD  = 4'd5;
    localparam logic [3:0] S_RL_CHK = 4'd6;
    localparam logic [3:0] S_RL_DEC = 4'd7;
    localparam logic [3:0] S_UP_RD  = 4'd8;
    localparam logic [3:0] S_UP_WR  = 4'd9;
    localparam logic [3:0] S_FIN    = 4'd10;

    logic [3:0]            state_reg, state_next;
    logic [COUNT_BITS-1:0] limit_reg;
    logic [NUM_BITS-1:0]   num_reg, num_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic [NUM_BITS-1:0]   idx_reg, idx_next;
    logic [NUM_BITS-1:0]   jdx_reg, jdx_next;
    logic [COUNT_BITS-1:0] page_reg, page_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0] lim_reg, lim_next;
    logic [COUNT_BITS-1:0] stop_reg, stop_next;
    ext_t                  prev_reg, prev_next;
    ext_t                  cur_reg, cur_next;
    logic                  have_cur_reg, have_cur_next;
    logic [2:0]            status_reg, status_next;
    logic [PAGE_BITS-1:0]  granted_reg, granted_next;

    logic                  rd_en;
    logic [ADDR_BITS-1:0]  rd_addr;
    ext_t                  rd_data;
    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    ext_t                  wr_data;

    logic [COUNT_BITS-1:0] req_page_ext;
    logic                  rel_bad;
    logic                  fit;
    logic [COUNT_BITS-1:0] new_lo;
    logic                  join_lo;
    logic                  join_hi;

    fepa_ram u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign req_page_ext = {1'b0, req_page};
    assign rel_bad = (req_page_ext == '0) || (req_count == '0) || (req_page_ext >= limit_reg)
                     || (req_count > (limit_reg - req_page_ext));

    assign fit = ((rd_data.hi - rd_data.lo) >= cnt_reg) && (rd_data.lo < lim_reg)
                 && (cnt_reg <= (lim_reg - rd_data.lo));
    assign new_lo  = rd_data.lo + cnt_reg;
    assign join_lo = (idx_reg != '0) && (prev_reg.hi == page_reg);
    assign join_hi = have_cur_reg && (cur_reg.lo == stop_reg);

    always_comb
    begin
        state_next    = state_reg;
        num_next      = num_reg;
        total_next    = total_reg;
        idx_next      = idx_reg;
        jdx_next      = jdx_reg;
        page_next     = page_reg;
        cnt_next      = cnt_reg;
        lim_next      = lim_reg;
        stop_next     = stop_reg;
        prev_next     = prev_reg;
        cur_next      = cur_reg;
        have_cur_next = have_cur_reg;
        status_next   = status_reg;
        granted_next  = granted_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg[ADDR_BITS-1:0];
        wr_en         = 1'b0;
        wr_addr       = idx_reg[ADDR_BITS-1:0];
        wr_data       = rd_data;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    page_next    = req_page_ext;
                    cnt_next     = req_count;
                    lim_next     = req_limit;
                    stop_next    = req_page_ext + req_count;
                    idx_next     = '0;
                    granted_next = '0;
                    status_next  = ST_OK;
                    if (req_action == ACT_ALLOC)
                    begin
                        if ((req_count == '0) || (req_count > limit_reg))
                        begin
                            status_next = ST_NOFIT;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            state_next = S_AL_RD;
                        end
                    end
                    else if (rel_bad)
                    begin
                        status_next = ST_BADREL;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        state_next = S_RL_RD;
                    end
                end
            end
            S_AL_RD:
            begin
                if (idx_reg == num_reg)
                begin
                    status_next = ST_NOFIT;
                    state_next  = S_FIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_AL_CHK;
                end
            end
            S_AL_CHK:
            begin
                if (fit)
                begin
                    granted_next = rd_data.lo[PAGE_BITS-1:0];
                    total_next   = total_reg - cnt_reg;
                    if (new_lo == rd_data.hi)
                    begin
                        jdx_next   = idx_reg + 1'b1;
                        state_next = S_DN_RD;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_data.lo = new_lo;
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_AL_RD;
                end
            end
            // Closing the gap: entry j moves to j-1 until the end of the table.
            S_DN_RD:
            begin
                if (jdx_reg >= num_reg)
                begin
                    num_next   = num_reg - 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = jdx_reg[ADDR_BITS-1:0];
                    state_next = S_DN_WR;
                end
            end
            S_DN_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = ADDR_BITS'(jdx_reg - 1'b1);
                jdx_next   = jdx_reg + 1'b1;
                state_next = S_DN_RD;
            end
            S_RL_RD:
            begin
                if (idx_reg == num_reg)
                begin
                    have_cur_next = 1'b0;
                    state_next    = S_RL_DEC;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_RL_CHK;
                end
            end
            S_RL_CHK:
            begin
                if (rd_data.hi <= page_reg)
                begin
                    prev_next  = rd_data;
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_RL_RD;
                end
                else
                begin
                    cur_next      = rd_data;
                    have_cur_next = 1'b1;
                    state_next    = S_RL_DEC;
                end
            end
            S_RL_DEC:
            begin
                if (have_cur_reg && (cur_reg.lo < stop_reg))
                begin
                    status_next = ST_OVERLAP;
                    state_next  = S_FIN;
                end
                else if (join_lo)
                begin
                    total_next = total_reg + cnt_reg;
                    wr_en      = 1'b1;
                    wr_addr    = ADDR_BITS'(idx_reg - 1'b1);
                    wr_data.lo = prev_reg.lo;
                    if (join_hi)
                    begin
                        wr_data.hi = cur_reg.hi;
                        jdx_next   = idx_reg + 1'b1;
                        state_next = S_DN_RD;
                    end
                    else
                    begin
                        wr_data.hi = stop_reg;
                        state_next = S_FIN;
                    end
                end
                else if (join_hi)
                begin
                    total_next = total_reg + cnt_reg;
                    wr_en      = 1'b1;
                    wr_data.lo = page_reg;
                    wr_data.hi = cur_reg.hi;
                    state_next = S_FIN;
                end
                else if (num_reg >= NUM_BITS'(SLOTS))
                begin
                    status_next = ST_FULL;
                    state_next  = S_FIN;
                end
                else
                begin
                    total_next = total_reg + cnt_reg;
                    jdx_next   = num_reg;
                    state_next = S_UP_RD;
                end
            end
            // Opening a gap: entry j-1 moves to j, down to the insert position.
            S_UP_RD:
            begin
                if (jdx_reg == idx_reg)
                begin
                    wr_en      = 1'b1;
                    wr_data.lo = page_reg;
                    wr_data.hi = stop_reg;
                    num_next   = num_reg + 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ADDR_BITS'(jdx_reg - 1'b1);
                    state_next = S_UP_WR;
                end
            end
            S_UP_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = jdx_reg[ADDR_BITS-1:0];
                jdx_next   = jdx_reg - 1'b1;
                state_next = S_UP_RD;
            end
            S_FIN:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            limit_reg <= LIMIT_RESET;
            num_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            num_reg   <= num_next;
            total_reg <= total_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        jdx_reg      <= jdx_next;
        page_reg     <= page_next;
        cnt_reg      <= cnt_next;
        lim_reg      <= lim_next;
        stop_reg     <= stop_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        have_cur_reg <= have_cur_next;
        status_reg   <= status_next;
        granted_reg  <= granted_next;
    end

    assign req_ready   = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_FIN);
    assign res.status  = status_reg;
    assign res.granted = granted_reg;
    assign res.total   = total_reg;

endmodule

// ===== rtl/fepa_checker.sv =====
module fepa_checker
    import fepa_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_BYTES*8-1:0] m_tdata
);

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result beat changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] == ST_OK) || (m_tdata[2:0] == ST_NOFIT)
            || (m_tdata[2:0] == ST_BADREL) || (m_tdata[2:0] == ST_OVERLAP)
            || (m_tdata[2:0] == ST_FULL))
        else $error("status code out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] != ST_OK) |-> (m_tdata[PAGE_BITS+2:3] == '0))
        else $error("page granted on a failed request");

endmodule

bind free_extent_page_allocator fepa_checker u_fepa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
